@@ hw/rtl/tpq_pkg.sv @@
// shared types and constants for the triangle plane quadric pipeline
package tpq_pkg;

  localparam int COORD_W = 24;
  localparam int LANES   = 10;
  localparam int NRM_W   = 30;   // scaled normal magnitude
  localparam int DEN_W   = 62;   // |n'|^2
  localparam int DM_W    = 56;   // |n'.a|
  localparam int NUM_W   = 118;  // dividend width
  localparam int QUO_W   = 56;   // quotient bits before rounding
  localparam int REM_W   = 62;
  localparam int OUT_W   = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [NUM_W-1:0]          num_t;
  typedef logic [DEN_W-1:0]          den_t;
  typedef logic signed [OUT_W-1:0]   quad_t;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

@@ hw/rtl/tpq_front.sv @@
// front pipeline: normal, scaling, denominator and dividends for all ten entries
module tpq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  tpq_pkg::coord_t               ax, ay, az, bx, by_coord, bz, cx, cy, cz,
  output tpq_pkg::ctl_t                 ctl,
  output tpq_pkg::den_t                 den,
  output tpq_pkg::num_t [tpq_pkg::LANES-1:0] num,
  output logic [tpq_pkg::LANES-1:0]     neg
);
  import tpq_pkg::*;

  logic [7:1] v;

  // stage 1: edges
  logic signed [24:0] u [3];
  logic signed [24:0] w [3];
  coord_t p1 [3];
  // stage 2: cross products
  logic signed [49:0] pr [6];
  coord_t p2 [3];
  // stage 3: normal magnitude and sign
  logic [50:0] nm [3];
  logic [2:0]  ng3;
  coord_t p3 [3];
  // stage 4: scaled normal
  logic [NRM_W-1:0] ns4 [3];
  logic [2:0]  ng4;
  logic        dg4;
  coord_t p4 [3];
  // stage 5: squares and plane offset terms
  logic [59:0] sq [3];
  logic signed [54:0] t5 [3];
  logic [NRM_W-1:0] ns5 [3];
  logic [2:0]  ng5;
  logic        dg5;
  // stage 6: sums
  den_t den6;
  logic [DM_W-1:0] dm6;
  logic        dn6;
  logic [NRM_W-1:0] ns6 [3];
  logic [2:0]  ng6;
  logic        dg6;
  // stage 7: partial products
  logic [59:0] pa [6];
  logic [57:0] pbl [3];
  logic [57:0] pbh [3];
  logic [55:0] cll, clh, chh;
  den_t den7;
  logic [LANES-1:0] ng7;
  logic        dg7;

  logic [50:0] orm;
  logic [5:0]  len, sh;
  logic [50:0] nsh [3];
  logic signed [55:0] tt [3];
  logic signed [56:0] dsum;
  logic [85:0] nb [3];
  logic [111:0] nc;
  num_t num_n [LANES];

  always_comb begin
    orm = nm[0] | nm[1] | nm[2];
    len = '0;
    for (int i = 0; i < 51; i++) begin
      if (orm[i]) len = 6'(i + 1);
    end
    sh = (len > 6'd30) ? len - 6'd30 : 6'd0;
    for (int i = 0; i < 3; i++) begin
      nsh[i] = nm[i] >> sh;
      tt[i]  = ng5[i] ? -56'(t5[i]) : 56'(t5[i]);
    end
    dsum = 57'(tt[0]) + 57'(tt[1]) + 57'(tt[2]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nb[i] = (86'(pbh[i]) << 28) + 86'(pbl[i]);
    end
    nc = (112'(chh) << 56) + (112'(clh) << 29) + 112'(cll);
    for (int i = 0; i < 6; i++) num_n[i] = NUM_W'(pa[i]) << 32;
    for (int i = 0; i < 3; i++) num_n[6+i] = NUM_W'(nb[i]) << 20;
    num_n[9] = NUM_W'(nc[109:0]) << 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      ctl <= '0;
    end else if (en) begin
      v   <= {v[6:1], in_valid};
      ctl <= '{valid: v[7], degen: dg7};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= {bx[23], bx} - {ax[23], ax};
      u[1] <= {by_coord[23], by_coord} - {ay[23], ay};
      u[2] <= {bz[23], bz} - {az[23], az};
      w[0] <= {cx[23], cx} - {ax[23], ax};
      w[1] <= {cy[23], cy} - {ay[23], ay};
      w[2] <= {cz[23], cz} - {az[23], az};
      p1[0] <= ax; p1[1] <= ay; p1[2] <= az;

      pr[0] <= u[1] * w[2];
      pr[1] <= u[2] * w[1];
      pr[2] <= u[2] * w[0];
      pr[3] <= u[0] * w[2];
      pr[4] <= u[0] * w[1];
      pr[5] <= u[1] * w[0];
      p2 <= p1;

      for (int i = 0; i < 3; i++) begin
        logic signed [50:0] n;
        n = {pr[2*i][49], pr[2*i]} - {pr[2*i+1][49], pr[2*i+1]};
        nm[i]  <= n[50] ? 51'(-n) : 51'(n);
        ng3[i] <= n[50];
      end
      p3 <= p2;

      for (int i = 0; i < 3; i++) ns4[i] <= nsh[i][NRM_W-1:0];
      ng4 <= ng3;
      dg4 <= (orm == '0);
      p4  <= p3;

      for (int i = 0; i < 3; i++) begin
        sq[i] <= ns4[i] * ns4[i];
        t5[i] <= $signed({1'b0, ns4[i]}) * p4[i];
      end
      ns5 <= ns4;
      ng5 <= ng4;
      dg5 <= dg4;

      den6 <= DEN_W'(sq[0]) + DEN_W'(sq[1]) + DEN_W'(sq[2]);
      dm6  <= dsum[56] ? DM_W'(-dsum) : DM_W'(dsum);
      dn6  <= dsum[56];
      ns6  <= ns5;
      ng6  <= ng5;
      dg6  <= dg5;

      pa[0] <= ns6[0] * ns6[0];
      pa[1] <= ns6[0] * ns6[1];
      pa[2] <= ns6[0] * ns6[2];
      pa[3] <= ns6[1] * ns6[1];
      pa[4] <= ns6[1] * ns6[2];
      pa[5] <= ns6[2] * ns6[2];
      for (int i = 0; i < 3; i++) begin
        pbl[i] <= ns6[i] * dm6[27:0];
        pbh[i] <= ns6[i] * dm6[55:28];
      end
      cll <= dm6[27:0] * dm6[27:0];
      clh <= dm6[27:0] * dm6[55:28];
      chh <= dm6[55:28] * dm6[55:28];
      den7 <= den6;
      ng7[0] <= 1'b0;
      ng7[1] <= ng6[0] ^ ng6[1];
      ng7[2] <= ng6[0] ^ ng6[2];
      ng7[3] <= 1'b0;
      ng7[4] <= ng6[1] ^ ng6[2];
      ng7[5] <= 1'b0;
      // b is negative when the normal component and the offset agree in sign
      for (int i = 0; i < 3; i++) ng7[6+i] <= ~(ng6[i] ^ dn6);
      ng7[9] <= 1'b0;
      dg7 <= dg6;

      for (int i = 0; i < LANES; i++) num[i] <= num_n[i];
      den <= den7;
      neg <= ng7;
    end
  end

endmodule

@@ hw/rtl/tpq_div.sv @@
// ten-lane pipelined restoring divider, one quotient bit per stage, with rounding
module tpq_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  tpq_pkg::ctl_t                      ctl_in,
  input  tpq_pkg::den_t                      den_in,
  input  tpq_pkg::num_t [tpq_pkg::LANES-1:0] num_in,
  input  logic [tpq_pkg::LANES-1:0]          neg_in,
  output tpq_pkg::ctl_t                      ctl_out,
  output tpq_pkg::quad_t [tpq_pkg::LANES-1:0] q_out
);
  import tpq_pkg::*;

  logic [REM_W-1:0] rem [0:QUO_W][LANES];
  logic [QUO_W-1:0] quo [0:QUO_W][LANES];
  den_t             dn  [0:QUO_W];
  logic [LANES-1:0] sg  [0:QUO_W];
  ctl_t             cs  [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0] <= '0;
    end else if (en) begin
      cs[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0] <= den_in;
      sg[0] <= neg_in;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= num_in[l][NUM_W-1:QUO_W];
        quo[0][l] <= num_in[l][QUO_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        cs[k+1] <= '0;
      end else if (en) begin
        cs[k+1] <= cs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn[k+1] <= dn[k];
        sg[k+1] <= sg[k];
        for (int l = 0; l < LANES; l++) begin
          logic [REM_W:0] r2;
          logic           ge;
          r2 = {rem[k][l], quo[k][l][QUO_W-1]};
          ge = (r2 >= {1'b0, dn[k]});
          rem[k+1][l] <= ge ? REM_W'(r2 - {1'b0, dn[k]}) : r2[REM_W-1:0];
          quo[k+1][l] <= {quo[k][l][QUO_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= cs[QUO_W];
    end
  end

  // round half away from zero on the magnitude, then apply the sign; a degenerate triangle gives zero in every lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        logic [OUT_W-1:0] q;
        q = OUT_W'(quo[QUO_W][l]) +
            OUT_W'({rem[QUO_W][l], 1'b0} >= {1'b0, dn[QUO_W]});
        if (cs[QUO_W].degen) q_out[l] <= '0;
        else if (sg[QUO_W][l]) q_out[l] <= -q;
        else q_out[l] <= q;
      end
    end
  end

endmodule

@@ hw/rtl/triangle_plane_quadric.sv @@
// plane error quadric of one triangle, fully pipelined
// usage:
//   input channel in_valid/in_ready carries the nine Q12.12 corner coordinates
//   of one triangle; a transaction completes when both are high at a clock edge
//   output channel out_valid/out_ready carries the ten Q31.32 quadric entries
//   and the degenerate flag (all entries zero when the normal vanishes)
//   from input transaction to out_valid the data passes through 8 front
//   stages (edges, cross product, scaling, multiplies) and 58 divider stages
//   (load, 56 restoring steps of one quotient bit each, rounding)
//   throughput: one triangle per cycle while the receiver does not stall; no state carries between triangles
//   the whole pipeline advances together; in_ready is high when the output
//   register is empty or being taken, so a stalled receiver freezes every
//   stage and a new transaction is taken in the cycle the stall lifts
//   rst (synchronous, active high) clears all valid bits; the block is ready
//   in the cycle after reset drops
module triangle_plane_quadric (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tpq_pkg::coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz,
  output logic            out_valid,
  input  logic            out_ready,
  output tpq_pkg::quad_t  q_xx, q_xy, q_xz, q_yy, q_yz, q_zz,
  output tpq_pkg::quad_t  q_xw, q_yw, q_zw, q_ww,
  output logic            degenerate
);
  import tpq_pkg::*;

  logic                    en;
  ctl_t                    f_ctl, d_ctl;
  den_t                    f_den;
  num_t [LANES-1:0]        f_num;
  logic [LANES-1:0]        f_neg;
  quad_t [LANES-1:0]       q;

  assign en       = ~d_ctl.valid | out_ready;
  assign in_ready = en;

  tpq_front u_front (
    .clk, .rst, .en, .in_valid,
    .ax, .ay, .az, .bx, .by_coord, .bz, .cx, .cy, .cz,
    .ctl(f_ctl), .den(f_den), .num(f_num), .neg(f_neg)
  );

  tpq_div u_div (
    .clk, .rst, .en,
    .ctl_in(f_ctl), .den_in(f_den), .num_in(f_num), .neg_in(f_neg),
    .ctl_out(d_ctl), .q_out(q)
  );

  assign out_valid  = d_ctl.valid;
  assign degenerate = d_ctl.degen;
  assign q_xx = q[0];
  assign q_xy = q[1];
  assign q_xz = q[2];
  assign q_yy = q[3];
  assign q_yz = q[4];
  assign q_zz = q[5];
  assign q_xw = q[6];
  assign q_yw = q[7];
  assign q_zw = q[8];
  assign q_ww = q[9];

endmodule

@@ hw/rtl/tpq_checker.sv @@
// port-level checks for the triangle plane quadric block
module tpq_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input tpq_pkg::quad_t  q_xx, q_yy, q_zz, q_xy, q_ww,
  input logic            degenerate
);
  import tpq_pkg::*;

  // a stalled result stays put (checked on q_xx and the degenerate flag)
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(q_xx) && $stable(degenerate))
    else $error("result dropped under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> q_xx == 0 && q_xy == 0 && q_ww == 0)
    else $error("degenerate triangle gave a nonzero quadric");

  // diagonal entries and the constant term never go negative
  a_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_xx[63] && !q_yy[63] && !q_zz[63] && !q_ww[63])
    else $error("negative diagonal entry");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind triangle_plane_quadric tpq_checker u_tpq_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .q_xx, .q_yy, .q_zz, .q_xy, .q_ww, .degenerate
);
